// ----- hdl/nsm_pkg.sv -----
// ---------------------------------------------------------------------------
// nsm_pkg
// Shared types and constants for the NFA symbol matcher: operation codes,
// the input and result word layouts and the edge load command.
// ---------------------------------------------------------------------------
`default_nettype none

package nsm_pkg;

    // Operation codes carried in the op field of an input word
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_FEED  = 2'd2
    } t_op;

    // states_in_use register
    localparam int          CFG_W     = 6;
    localparam logic [5:0]  CFG_RESET = 6'd32;

    // Input word
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] symbol;
        logic [4:0] state_index;
        logic [1:0] edge_slot;
        logic [4:0] edge_target;
        logic       edge_enable;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic alive;
        logic accepted;
    } t_out_word;

    // Edge slot write, broadcast along the cell row
    typedef struct packed {
        logic       we;
        logic [4:0] src;
        logic [1:0] slot;
        logic [7:0] symbol;
        logic [4:0] target;
        logic       enable;
    } t_load_cmd;

endpackage

`default_nettype wire

// ----- hdl/nsm_stream_if.sv -----
// ---------------------------------------------------------------------------
// nsm_stream_if
// Valid/ready stream channel carrying one word of type T per handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface nsm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/nsm_cell.sv -----
// ---------------------------------------------------------------------------
// nsm_cell
// One automaton state: holds its active bit and its edge slots, and adds
// the targets it reaches on the current symbol to the hit vector that runs
// along the row of cells.
// ---------------------------------------------------------------------------
`default_nettype none

module nsm_cell
    import nsm_pkg::*;
#(
    parameter int NUM_STATES      = 32,
    parameter int EDGES_PER_STATE = 4,
    parameter int CELL_IDX        = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_load_cmd             i_load,
    input  wire logic [7:0]            i_symbol,
    input  wire logic                  i_used,
    input  wire logic                  i_active_d,
    input  wire logic [NUM_STATES-1:0] i_hits,
    output logic      [NUM_STATES-1:0] o_hits,
    output logic                       o_active
);

    logic [EDGES_PER_STATE-1:0] r_valid;
    logic [7:0]                 r_sym [EDGES_PER_STATE];
    logic [4:0]                 r_tgt [EDGES_PER_STATE];
    logic                       r_active;
    logic                       w_sel;
    logic [NUM_STATES-1:0]      w_hits;

    // load addressed to this state
    assign w_sel = i_load.we && (32'(i_load.src) == CELL_IDX);

    // edge slots: valid bits reset, symbol and target are payload
    always_ff @(posedge i_clk) begin
        for (int e = 0; e < EDGES_PER_STATE; e++) begin
            if (w_sel && (32'(i_load.slot) == e)) begin
                r_sym[e] <= i_load.symbol;
                r_tgt[e] <= i_load.target;
            end
        end
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int e = 0; e < EDGES_PER_STATE; e++) begin
                if (w_sel && (32'(i_load.slot) == e)) begin
                    r_valid[e] <= i_load.enable;
                end
            end
        end
    end

    // active bit, state 0 is active out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= (CELL_IDX == 0);
        end else begin
            r_active <= i_active_d;
        end
    end

    // targets reached on this symbol, merged into the row's hit vector
    always_comb begin
        w_hits = '0;
        for (int e = 0; e < EDGES_PER_STATE; e++) begin
            for (int t = 0; t < NUM_STATES; t++) begin
                if (r_active && i_used && r_valid[e] && (r_sym[e] == i_symbol)
                        && (32'(r_tgt[e]) == t)) begin
                    w_hits[t] = 1'b1;
                end
            end
        end
    end

    assign o_hits   = i_hits | w_hits;
    assign o_active = r_active;

endmodule

`default_nettype wire

// ----- hdl/nfa_symbol_matcher_core.sv -----
// ---------------------------------------------------------------------------
// nfa_symbol_matcher_core
// Runs a nondeterministic automaton without empty moves over a stream of
// characters: edge loads, lexeme starts and symbol feeds, one result word
// (alive, accepted) per input word.
// ---------------------------------------------------------------------------
// Takes one input word every clock cycle. A word's result is registered
// into the output register, or the skid word while the output stalls;
// this two-word buffer lets input continue while a result waits, and the
// input stalls only when both places are full. The whole next active set
// is formed combinationally: every cell compares the symbol with its edge
// slots and ORs its targets into the hit vector passed down the row of
// NUM_STATES cells, which sets the clock period. The edge table lives in
// the cells' flip-flops, so there is no clearing pass after reset.
`default_nettype none

module nfa_symbol_matcher_core
    import nsm_pkg::*;
#(
    parameter int NUM_STATES      = 32,
    parameter int EDGES_PER_STATE = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    nsm_stream_if.sink              i_in,
    nsm_stream_if.source            o_out,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata
);

    logic [CFG_W-1:0]      r_cfg;
    logic                  r_dead, n_dead;
    logic [NUM_STATES-1:0] n_active;
    logic [NUM_STATES-1:0] w_cur;
    logic [NUM_STATES-1:0] w_used;
    logic [NUM_STATES-1:0] w_last;
    logic [NUM_STATES-1:0] w_next;
    logic [NUM_STATES-1:0] w_chain [NUM_STATES+1];
    logic                  w_acc, w_start, w_feed;
    t_in_word              w_in;
    t_load_cmd             w_load;
    t_out_word             w_res;
    logic                  r_out_v, r_skid_v;
    t_out_word             r_out_d, r_skid_d;

    assign w_in    = i_in.data;
    assign w_acc   = i_in.valid && i_in.ready;
    assign w_start = w_acc && (w_in.op == OP_START);
    assign w_feed  = w_acc && (w_in.op == OP_FEED);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // states in use (zero acts as one) and the accepting state
    always_comb begin
        for (int i = 0; i < NUM_STATES; i++) begin
            w_used[i] = (i == 0) || (32'(r_cfg) > i);
        end
        w_last = w_used & ~(w_used >> 1);
    end

    // edge load broadcast
    always_comb begin
        w_load.we     = w_acc && (w_in.op == OP_LOAD);
        w_load.src    = w_in.state_index;
        w_load.slot   = w_in.edge_slot;
        w_load.symbol = w_in.symbol;
        w_load.target = w_in.edge_target;
        w_load.enable = w_in.edge_enable;
    end

    // row of state cells
    assign w_chain[0] = '0;

    for (genvar s = 0; s < NUM_STATES; s++) begin : g_cell
        nsm_cell #(
            .NUM_STATES      (NUM_STATES),
            .EDGES_PER_STATE (EDGES_PER_STATE),
            .CELL_IDX        (s)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (w_load),
            .i_symbol   (w_in.symbol),
            .i_used     (w_used[s]),
            .i_active_d (n_active[s]),
            .i_hits     (w_chain[s]),
            .o_hits     (w_chain[s+1]),
            .o_active   (w_cur[s])
        );
    end

    assign w_next = w_chain[NUM_STATES] & w_used;

    // next active set, dead flag and the result word
    always_comb begin
        priority if (w_start) begin
            n_active = NUM_STATES'(1);
            n_dead   = 1'b0;
        end else if (w_feed) begin
            n_active = r_dead ? '0 : w_next;
            n_dead   = r_dead || (w_next == '0);
        end else begin
            n_active = w_cur;
            n_dead   = r_dead;
        end
        w_res.alive    = !n_dead && ((n_active & w_used) != '0);
        w_res.accepted = w_res.alive && ((n_active & w_last) != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead <= 1'b0;
        end else begin
            r_dead <= n_dead;
        end
    end

    // output register with one skid word behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (o_out.ready) begin
                    r_skid_v <= 1'b0;
                end
            end else if (w_acc) begin
                if (r_out_v && !o_out.ready) begin
                    r_skid_v <= 1'b1;
                end
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (o_out.ready) begin
                r_out_d <= r_skid_d;
            end
        end else if (w_acc) begin
            if (r_out_v && !o_out.ready) begin
                r_skid_d <= w_res;
            end else begin
                r_out_d <= w_res;
            end
        end
    end

    assign i_in.ready  = !r_skid_v;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out_d;

endmodule

`default_nettype wire

// ----- hdl/nsm_checker.sv -----
// ---------------------------------------------------------------------------
// nsm_checker
// Port-level checks on the NFA symbol matcher, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module nsm_checker
    import nsm_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire t_in_word  i_in_data,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_word i_out_data
);

    // a word on the output never claims acceptance while dead
    a_accept_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.alive || !i_out_data.accepted))
        else $error("accepted reported without alive");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("output word changed while stalled");

    // input only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

    // a start into an empty output gives an alive word next cycle
    a_start_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_data.op == OP_START) && !i_out_valid)
            |=> (i_out_valid && i_out_data.alive))
        else $error("start did not report alive");

endmodule

bind nfa_symbol_matcher_core nsm_checker u_nsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_data   (i_in.data),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire

// ----- dv/nsm_match_checker.sv -----
// ---------------------------------------------------------------------------
// nsm_match_checker
// Watches the input, result and configuration ports of the NFA symbol
// matcher, keeps its own copy of the edge table, active set and dead flag,
// predicts the alive/accepted flags of every accepted input word and
// compares them, in order, with the result words the block hands out.
// ---------------------------------------------------------------------------
`default_nettype none

module nsm_match_checker
    import nsm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire t_in_word          i_in_data,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire t_out_word         i_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STATE_COUNT = 32;
    localparam int SLOTS       = 4;
    localparam int TABLE_DEPTH = STATE_COUNT * SLOTS;

    // Shadow of the automaton
    bit               edge_on  [TABLE_DEPTH];
    logic [7:0]       edge_sym [TABLE_DEPTH];
    logic [4:0]       edge_dst [TABLE_DEPTH];
    logic [31:0]      live_set;
    bit               dead;
    logic [CFG_W-1:0] state_limit;

    t_out_word awaited_flags [$];
    int        mismatch_total;
    int        checked_total;

    // states_in_use clamped to 1..STATE_COUNT
    function automatic int used_states();
        if (state_limit == '0)
            return 1;
        if (int'(state_limit) > STATE_COUNT)
            return STATE_COUNT;
        return int'(state_limit);
    endfunction

    // Apply one input word to the shadow and return the flags it reports
    function automatic t_out_word advance_automaton(t_in_word w);
        int          n;
        int          k;
        int          s;
        int          e;
        logic [31:0] next_set;
        logic [31:0] in_use;
        t_out_word   r;
        n = used_states();
        case (w.op)
            OP_LOAD: begin
                k = int'(w.state_index) * SLOTS + int'(w.edge_slot);
                edge_sym[k] = w.symbol;
                edge_dst[k] = w.edge_target;
                edge_on[k]  = w.edge_enable;
            end
            OP_START: begin
                live_set = 32'd1;
                dead     = 1'b0;
            end
            OP_FEED: begin
                if (dead) begin
                    live_set = '0;
                end else begin
                    next_set = '0;
                    for (s = 0; s < n; s++) begin
                        if (live_set[s]) begin
                            for (e = 0; e < SLOTS; e++) begin
                                k = s * SLOTS + e;
                                if (edge_on[k] && edge_sym[k] == w.symbol
                                        && int'(edge_dst[k]) < n)
                                    next_set[edge_dst[k]] = 1'b1;
                            end
                        end
                    end
                    live_set = next_set;
                    if (next_set == '0)
                        dead = 1'b1;
                end
            end
            default: begin
                // unused op: report only
            end
        endcase
        in_use     = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
        r.alive    = !dead && ((live_set & in_use) != '0);
        r.accepted = r.alive && live_set[n-1];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input t_out_word want,
                                 input t_out_word got);
        mismatch_total++;
        if (mismatch_total <= 10)
            $display("[%0t] %s: expected alive=%0b accepted=%0b, got alive=%0b accepted=%0b",
                     $time, what, want.alive, want.accepted, got.alive, got.accepted);
    endtask

    // Track inputs, configuration and results at each rising edge
    always @(posedge i_clk) begin : track
        t_out_word want;
        if (!i_rst_n) begin
            foreach (edge_on[i]) begin
                edge_on[i]  = 1'b0;
                edge_sym[i] = '0;
                edge_dst[i] = '0;
            end
            live_set    = 32'd1;
            dead        = 1'b0;
            state_limit = CFG_RESET;
            awaited_flags.delete();
        end else begin
            if (i_cfg_we)
                state_limit = i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                awaited_flags.push_back(advance_automaton(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (awaited_flags.size() == 0) begin
                    flag_mismatch("result word with nothing outstanding", '0, i_out_data);
                end else begin
                    want = awaited_flags.pop_front();
                    checked_total++;
                    if (i_out_data.alive !== want.alive
                            || i_out_data.accepted !== want.accepted)
                        flag_mismatch("result word mismatch", want, i_out_data);
                end
            end
        end
        o_fail_count <= mismatch_total;
        o_pending    <= awaited_flags.size();
        o_checked    <= checked_total;
    end

endmodule

`default_nettype wire

// ----- dv/nfa_symbol_matcher_core_tb.sv -----
// ---------------------------------------------------------------------------
// nfa_symbol_matcher_core_tb
// Drives edge loads, lexeme starts, symbol words and unused op words into
// the NFA matcher under several states_in_use settings, with random idling
// on both sides, and leaves prediction and comparison to nsm_match_checker.
// ---------------------------------------------------------------------------
`default_nettype none

module nfa_symbol_matcher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nsm_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASES      = 7;
    localparam int         PHASE_WORDS = 45;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    nsm_stream_if #(.T(t_in_word))  in_ch  ();
    nsm_stream_if #(.T(t_out_word)) out_ch ();

    int fail_count;
    int pending;
    int checked;

    int          cycle_count;
    int          sink_hold;
    bit          source_idle_on;
    bit          sink_idle_on;
    int          load_words;
    int          start_words;
    int          feed_words;
    int          spare_words;
    int          limit_writes;
    int unsigned limit_plan [PHASES];

    nfa_symbol_matcher_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    nsm_match_checker match_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still outstanding",
                     cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Result side back-pressure in random bursts
    always @(posedge clk) begin
        if (sink_hold != 0) begin
            sink_hold    <= sink_hold - 1;
            out_ch.ready <= (sink_hold == 1);
        end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
            sink_hold    <= $urandom_range(1, 12);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // states_in_use as the block treats it
    function automatic int effective_states(int unsigned v);
        if (v == 0)
            return 1;
        if (v > 32)
            return 32;
        return int'(v);
    endfunction

    // Character from the small per-phase alphabet
    function automatic logic [7:0] alphabet_symbol(logic [7:0] base);
        return base + 8'($urandom_range(0, 3));
    endfunction

    // Offer one word, maybe after a gap, and wait until it is taken
    task automatic send_word(input t_in_word w);
        int gap;
        if (source_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        case (w.op)
            OP_LOAD:  load_words++;
            OP_START: start_words++;
            OP_FEED:  feed_words++;
            default:  spare_words++;
        endcase
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_fields(input logic [1:0] op, input int sym, input int src,
                               input int slot, input int tgt, input bit en);
        t_in_word w;
        w.op          = op;
        w.symbol      = 8'(sym);
        w.state_index = 5'(src);
        w.edge_slot   = 2'(slot);
        w.edge_target = 5'(tgt);
        w.edge_enable = en;
        send_word(w);
    endtask

    // Stop offering and wait until every result word has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_limit(input int unsigned v);
        cfg_wdata <= CFG_W'(v);
        cfg_we    <= 1'b1;
        limit_writes++;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random word: mostly symbols from the alphabet within lexemes
    function automatic t_in_word make_random_word(int n, logic [7:0] base);
        t_in_word w;
        int       pick;
        w.op          = OP_FEED;
        w.symbol      = 8'($urandom_range(0, 255));
        w.state_index = 5'($urandom_range(0, 31));
        w.edge_slot   = 2'($urandom_range(0, 3));
        w.edge_target = 5'($urandom_range(0, 31));
        w.edge_enable = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            w.op = OP_LOAD;
            if ($urandom_range(0, 4) != 0)
                w.state_index = 5'($urandom_range(0, n - 1));
            if ($urandom_range(0, 6) != 0)
                w.edge_target = 5'($urandom_range(0, n - 1));
            if ($urandom_range(0, 3) != 0)
                w.symbol = alphabet_symbol(base);
            if ($urandom_range(0, 6) != 0)
                w.edge_enable = 1'b1;
        end else if (pick < 20) begin
            w.op = OP_START;
        end else if (pick < 95) begin
            if ($urandom_range(0, 6) != 0)
                w.symbol = alphabet_symbol(base);
        end else begin
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    // Stimulus
    initial begin
        int         ph;
        int         i;
        int         n;
        logic [7:0] base;
        t_in_word   w;

        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        rst_n          = 1'b0;
        source_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        limit_plan     = '{5, 1, 0, 63, 32, 12, 2};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, states_in_use at its reset value
        send_fields(OP_UNUSED, 255, 31, 3, 31, 1'b1);   // reset state reported
        send_fields(OP_FEED,   0,   0,  0, 0,  1'b0);   // no edges: dies
        send_fields(OP_FEED,   255, 0,  0, 0,  1'b0);   // fed while dead
        send_fields(OP_START,  0,   0,  0, 0,  1'b0);
        send_fields(OP_LOAD,   8'h61, 0,  0, 31, 1'b1);
        send_fields(OP_LOAD,   8'h00, 0,  1, 1,  1'b1);
        send_fields(OP_LOAD,   8'h61, 0,  2, 2,  1'b1);
        send_fields(OP_LOAD,   8'hFF, 31, 3, 0,  1'b1);
        send_fields(OP_LOAD,   8'hFF, 2,  0, 31, 1'b1);
        send_fields(OP_FEED,   8'h61, 0,  0, 0,  1'b0);  // two targets on one symbol
        send_fields(OP_FEED,   8'hFF, 0,  0, 0,  1'b0);  // accepting state loops back
        send_fields(OP_FEED,   8'h61, 0,  0, 0,  1'b0);
        send_fields(OP_START,  0,   0,  0, 0,  1'b0);   // restart clears stale set
        send_fields(OP_FEED,   8'h00, 0,  0, 0,  1'b0);
        send_fields(OP_FEED,   8'h42, 0,  0, 0,  1'b0);  // no match: dies
        send_fields(OP_UNUSED, 0,   0,  0, 0,  1'b0);   // unused op while dead
        send_fields(OP_FEED,   8'h61, 0,  0, 0,  1'b0);
        send_fields(OP_START,  0,   0,  0, 0,  1'b0);
        send_fields(OP_LOAD,   8'h61, 0,  0, 31, 1'b0);  // edge removed
        send_fields(OP_FEED,   8'h61, 0,  0, 0,  1'b0);
        send_fields(OP_FEED,   8'hFF, 0,  0, 0,  1'b0);
        send_fields(OP_LOAD,   8'h00, 31, 0, 0,  1'b1);
        send_fields(OP_FEED,   8'h00, 0,  0, 0,  1'b0);

        // Random phases, one states_in_use setting each
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 1) begin
                source_idle_on <= 1'b0;
                sink_idle_on   <= 1'b0;
            end
            drain();
            write_limit(limit_plan[ph]);
            n    = effective_states(limit_plan[ph]);
            base = 8'($urandom_range(0, 255));

            // seed the edge table with edges inside the states in use
            for (i = 0; i < 2 * ((n < 12) ? n : 12); i++) begin
                send_fields(OP_LOAD, alphabet_symbol(base), i % n,
                            $urandom_range(0, 3), $urandom_range(0, n - 1), 1'b1);
            end
            for (i = 0; i < PHASE_WORDS; i++) begin
                w = make_random_word(n, base);
                send_word(w);
            end
        end

        drain();
        repeat (4) @(posedge clk);

        $display("Sent %0d words: %0d loads, %0d starts, %0d feeds, %0d unused ops",
                 load_words + start_words + feed_words + spare_words,
                 load_words, start_words, feed_words, spare_words);
        $display("Checked %0d results over %0d states_in_use writes (0, 1, 32, 63 included)",
                 checked, limit_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
